@@ design/meter_frame_command_handler_core_macros.svh @@
// Assertion macros shared by the meter frame command handler modules.
`ifndef METER_FRAME_COMMAND_HANDLER_CORE_MACROS_SVH
`define METER_FRAME_COMMAND_HANDLER_CORE_MACROS_SVH

`ifndef SYNTH

`define MFCH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define MFCH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MFCH_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define MFCH_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ design/mfch_pkg.sv @@
// Types, constants and the control program of the meter frame command handler.
package mfch_pkg;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] REG_TIMEOUT    = 2'd0;
   localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
   localparam logic [1:0] REG_MAX_HEIGHT = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET    = 16'd5000;
   localparam logic [9:0]  MAX_WIDTH_RESET  = 10'd640;
   localparam logic [9:0]  MAX_HEIGHT_RESET = 10'd480;

   localparam logic [7:0] START_BYTE     = 8'h68;
   localparam logic [7:0] END_BYTE       = 8'h16;
   localparam logic [7:0] CTRL_BYTE      = 8'h10;
   localparam logic [7:0] ADDR_FILL      = 8'hAA;
   localparam logic [7:0] CMD_GET_DATA   = 8'h17;
   localparam logic [7:0] CMD_SET_CENTRE = 8'h18;
   localparam logic [7:0] CMD_GET_CENTRE = 8'h19;
   localparam logic [7:0] RSP_SET_CENTRE = 8'h98;
   localparam logic [7:0] RSP_GET_CENTRE = 8'h99;
   localparam logic [7:0] LEN_SET_ACK    = 8'h03;
   localparam logic [7:0] LEN_GET_REPLY  = 8'h0A;
   localparam logic [7:0] LEN_HIGH       = 8'h00;
   localparam logic [7:0] STATUS_OK      = 8'h01;
   localparam logic [7:0] DATA_TAG       = 8'h01;

   localparam logic [4:0] FRAME_LEN  = 5'd23;
   localparam logic [4:0] CMD_INDEX  = 5'd9;
   localparam logic [4:0] SUM_FIRST  = 5'd11;
   localparam logic [4:0] SUM_LAST   = 5'd20;
   localparam logic [4:0] X_INDEX    = 5'd13;
   localparam logic [4:0] CHK_INDEX  = 5'd21;
   localparam logic [4:0] LAST_INDEX = 5'd22;
   localparam int         FIELD_BYTES = 8;

   localparam int         PC_WIDTH   = 5;
   localparam logic [PC_WIDTH-1:0] ENTRY_GET_DATA   = 5'd0;
   localparam logic [PC_WIDTH-1:0] ENTRY_SET_CENTRE = 5'd1;
   localparam logic [PC_WIDTH-1:0] ENTRY_GET_CENTRE = 5'd2;
   localparam logic [PC_WIDTH-1:0] PC_FILL_LOOP     = 5'd4;
   localparam logic [PC_WIDTH-1:0] PC_GET_TAIL      = 5'd13;
   localparam logic [2:0]          FILL_COUNT       = 3'd7;

   typedef enum logic [3:0] {
      SRC_LIT, SRC_PKT, SRC_REPLY, SRC_SUM,
      SRC_CX_LO, SRC_CX_HI, SRC_CY_LO, SRC_CY_HI,
      SRC_W_LO, SRC_W_HI, SRC_H_LO, SRC_H_HI
   } src_type;

   typedef enum logic [1:0] {SUM_NONE, SUM_LOAD, SUM_ADD} sum_op_type;

   typedef enum logic [1:0] {COND_NEXT, COND_LOOP, COND_GET} cond_type;

   typedef struct packed {
      src_type             src;
      logic [7:0]          lit;
      logic                emit;
      logic                kind;
      logic                last;
      sum_op_type          sum_op;
      logic                loop_load;
      logic                store;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic                valid;
      logic [PC_WIDTH-1:0] entry;
      logic                is_get;
   } start_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
   } frame_fields_type;

   function automatic ucode_type ucode_rom(input logic [PC_WIDTH-1:0] addr);
      ucode_type word;
      word = '{src: SRC_LIT, lit: 8'h00, emit: 1'b1, kind: 1'b0, last: 1'b0,
               sum_op: SUM_ADD, loop_load: 1'b0, store: 1'b0, cond: COND_NEXT,
               target: '0};
      case (addr)
         5'd0: begin
            word.src    = SRC_PKT;
            word.kind   = 1'b1;
            word.last   = 1'b1;
            word.sum_op = SUM_NONE;
         end
         5'd1: begin
            word.emit   = 1'b0;
            word.store  = 1'b1;
            word.sum_op = SUM_NONE;
         end
         5'd2: begin
            word.lit    = START_BYTE;
            word.sum_op = SUM_NONE;
         end
         5'd3: begin
            word.lit       = CTRL_BYTE;
            word.sum_op    = SUM_NONE;
            word.loop_load = 1'b1;
         end
         5'd4: begin
            word.lit    = ADDR_FILL;
            word.sum_op = SUM_NONE;
            word.cond   = COND_LOOP;
            word.target = PC_FILL_LOOP;
         end
         5'd5: begin
            word.src    = SRC_REPLY;
            word.sum_op = SUM_NONE;
            word.cond   = COND_GET;
            word.target = PC_GET_TAIL;
         end
         5'd6: begin
            word.lit    = LEN_SET_ACK;
            word.sum_op = SUM_LOAD;
         end
         5'd7:  word.lit = LEN_HIGH;
         5'd8:  word.lit = CMD_SET_CENTRE;
         5'd9:  word.lit = DATA_TAG;
         5'd10: word.lit = STATUS_OK;
         5'd11: begin
            word.src    = SRC_SUM;
            word.sum_op = SUM_NONE;
         end
         5'd12: begin
            word.lit    = END_BYTE;
            word.sum_op = SUM_NONE;
            word.last   = 1'b1;
         end
         5'd13: begin
            word.lit    = LEN_GET_REPLY;
            word.sum_op = SUM_LOAD;
         end
         5'd14: word.lit = LEN_HIGH;
         5'd15: word.lit = CMD_GET_CENTRE;
         5'd16: word.lit = DATA_TAG;
         5'd17: word.src = SRC_CX_LO;
         5'd18: word.src = SRC_CX_HI;
         5'd19: word.src = SRC_CY_LO;
         5'd20: word.src = SRC_CY_HI;
         5'd21: word.src = SRC_W_LO;
         5'd22: word.src = SRC_W_HI;
         5'd23: word.src = SRC_H_LO;
         5'd24: word.src = SRC_H_HI;
         5'd25: begin
            word.src    = SRC_SUM;
            word.sum_op = SUM_NONE;
         end
         5'd26: begin
            word.lit    = END_BYTE;
            word.sum_op = SUM_NONE;
            word.last   = 1'b1;
         end
         default: begin
            word.emit   = 1'b0;
            word.sum_op = SUM_NONE;
            word.last   = 1'b1;
         end
      endcase
      return word;
   endfunction

endpackage

@@ design/mfch_rx.sv @@
// Frame receiver: collects bytes, checks the frame, ages it with ticks and dispatches commands.
`include "meter_frame_command_handler_core_macros.svh"

module mfch_rx (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      opcode,
   input  logic [7:0]                rx_byte,
   input  logic [15:0]               timeout_ticks,
   output mfch_pkg::start_type       start,
   output mfch_pkg::frame_fields_type fields
);
   import mfch_pkg::*;

   logic [4:0]  count_ff, count_in;
   logic        receiving_ff, receiving_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  chk_ff, chk_in;
   logic [7:0]  data_ff [FIELD_BYTES];
   logic [7:0]  data_in [FIELD_BYTES];
   logic        is_start;

   always_comb begin
      count_in     = count_ff;
      receiving_in = receiving_ff;
      elapsed_in   = elapsed_ff;
      cmd_in       = cmd_ff;
      sum_in       = sum_ff;
      chk_in       = chk_ff;
      data_in      = data_ff;
      start        = '0;
      is_start     = !receiving_ff && (rx_byte == START_BYTE);
      if (accept) begin
         if (opcode == OP_TICK) begin
            if (receiving_ff) begin
               if (elapsed_ff != 16'hFFFF) begin
                  elapsed_in = elapsed_ff + 16'd1;
               end
               if (elapsed_in >= timeout_ticks && count_ff != 5'd0) begin
                  receiving_in = 1'b0;
                  count_in     = 5'd0;
                  elapsed_in   = 16'd0;
               end
            end
         end else begin
            if (is_start) begin
               receiving_in = 1'b1;
               elapsed_in   = 16'd0;
            end
            if ((receiving_ff || is_start) && count_ff < FRAME_LEN) begin
               count_in = count_ff + 5'd1;
               if (count_ff == CMD_INDEX) begin
                  cmd_in = rx_byte;
               end
               if (count_ff == SUM_FIRST) begin
                  sum_in = rx_byte;
               end else if (count_ff > SUM_FIRST && count_ff <= SUM_LAST) begin
                  sum_in = sum_ff + rx_byte;
               end
               if (count_ff == CHK_INDEX) begin
                  chk_in = rx_byte;
               end
               for (int i = 0; i < FIELD_BYTES; i++) begin
                  if (count_ff == X_INDEX + 5'(i)) begin
                     data_in[i] = rx_byte;
                  end
               end
               if (count_ff == LAST_INDEX && rx_byte == END_BYTE && chk_ff == sum_ff) begin
                  receiving_in = 1'b0;
                  count_in     = 5'd0;
                  elapsed_in   = 16'd0;
                  case (cmd_ff)
                     CMD_GET_DATA: begin
                        start = '{valid: 1'b1, entry: ENTRY_GET_DATA, is_get: 1'b0};
                     end
                     CMD_SET_CENTRE: begin
                        start = '{valid: 1'b1, entry: ENTRY_SET_CENTRE, is_get: 1'b0};
                     end
                     CMD_GET_CENTRE: begin
                        start = '{valid: 1'b1, entry: ENTRY_GET_CENTRE, is_get: 1'b1};
                     end
                     default: start = '0;
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 5'd0;
         receiving_ff <= 1'b0;
         elapsed_ff   <= 16'd0;
      end else begin
         count_ff     <= count_in;
         receiving_ff <= receiving_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      sum_ff  <= sum_in;
      chk_ff  <= chk_in;
      data_ff <= data_in;
   end

   assign fields.x = {data_ff[1], data_ff[0]};
   assign fields.y = {data_ff[3], data_ff[2]};
   assign fields.w = {data_ff[5], data_ff[4]};
   assign fields.h = {data_ff[7], data_ff[6]};

   `MFCH_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, count_ff <= FRAME_LEN, "count overrun")
   `MFCH_ASSERT_IMP(a_idle_empty, clock, reset, !receiving_ff, count_ff == 5'd0, "stale count")
   `MFCH_ASSERT_NXT(a_start_clears, clock, reset, start.valid, !receiving_ff && count_ff == 5'd0, "frame kept")

endmodule

@@ design/mfch_seq.sv @@
// Microcoded reply sequencer: control program, centre registers and the result register.
`include "meter_frame_command_handler_core_macros.svh"

module mfch_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  mfch_pkg::start_type        start,
   input  mfch_pkg::frame_fields_type fields,
   input  logic [9:0]                 max_width,
   input  logic [9:0]                 max_height,
   output logic                       busy,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last
);
   import mfch_pkg::*;

   logic                busy_ff, busy_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   logic                is_get_ff, is_get_in;
   logic [2:0]          loop_ff, loop_in;
   logic [7:0]          sum_ff, sum_in;
   logic [9:0]          cx_ff, cx_in, cy_ff, cy_in, cw_ff, cw_in, ch_ff, ch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   ucode_type           uw;
   logic [7:0]          data;
   logic                fire;

   always_comb begin
      uw = ucode_rom(pc_ff);
      case (uw.src)
         SRC_LIT:   data = uw.lit;
         SRC_PKT:   data = fields.x[7:0];
         SRC_REPLY: data = is_get_ff ? RSP_GET_CENTRE : RSP_SET_CENTRE;
         SRC_SUM:   data = sum_ff;
         SRC_CX_LO: data = cx_ff[7:0];
         SRC_CX_HI: data = {6'd0, cx_ff[9:8]};
         SRC_CY_LO: data = cy_ff[7:0];
         SRC_CY_HI: data = {6'd0, cy_ff[9:8]};
         SRC_W_LO:  data = cw_ff[7:0];
         SRC_W_HI:  data = {6'd0, cw_ff[9:8]};
         SRC_H_LO:  data = ch_ff[7:0];
         SRC_H_HI:  data = {6'd0, ch_ff[9:8]};
         default:   data = uw.lit;
      endcase
      fire = busy_ff && (!uw.emit || !rsp_valid_ff || !rsp_stall);

      busy_in      = busy_ff;
      pc_in        = pc_ff;
      is_get_in    = is_get_ff;
      loop_in      = loop_ff;
      sum_in       = sum_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cw_in        = cw_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (start.valid) begin
         busy_in   = 1'b1;
         pc_in     = start.entry;
         is_get_in = start.is_get;
      end else if (fire) begin
         case (uw.sum_op)
            SUM_LOAD: sum_in = data;
            SUM_ADD:  sum_in = sum_ff + data;
            default:  sum_in = sum_ff;
         endcase
         if (uw.loop_load) begin
            loop_in = FILL_COUNT;
         end
         if (uw.store) begin
            cx_in = (fields.x >= {6'd0, max_width})  ? 10'd0 : fields.x[9:0];
            cy_in = (fields.y >= {6'd0, max_height}) ? 10'd0 : fields.y[9:0];
            cw_in = (fields.w >  {6'd0, max_width})  ? max_width : fields.w[9:0];
            ch_in = (fields.h >  {6'd0, max_height}) ? max_height : fields.h[9:0];
         end
         if (uw.emit) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = uw.kind;
            rsp_byte_in  = data;
            rsp_last_in  = uw.last;
         end
         case (uw.cond)
            COND_LOOP: begin
               if (loop_ff != 3'd1) begin
                  loop_in = loop_ff - 3'd1;
                  pc_in   = uw.target;
               end else begin
                  pc_in = pc_ff + 5'd1;
               end
            end
            COND_GET: pc_in = is_get_ff ? uw.target : pc_ff + 5'd1;
            default:  pc_in = pc_ff + 5'd1;
         endcase
         if (uw.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         is_get_ff    <= 1'b0;
         loop_ff      <= 3'd0;
         cx_ff        <= 10'd0;
         cy_ff        <= 10'd0;
         cw_ff        <= 10'd0;
         ch_ff        <= 10'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         is_get_ff    <= is_get_in;
         loop_ff      <= loop_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cw_ff        <= cw_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   `MFCH_ASSERT_IMP(a_start_when_idle, clock, reset, start.valid, !busy_ff, "start while busy")
   `MFCH_ASSERT_IMP(a_request_is_last, clock, reset, rsp_valid_ff && rsp_kind_ff, rsp_last_ff, "request not last")
   `MFCH_ASSERT_NXT(a_end_goes_idle, clock, reset, fire && uw.last, !busy_ff, "program kept running")

endmodule

@@ design/meter_frame_command_handler_core.sv @@
// Top level of the meter frame command handler: control registers, receiver and sequencer.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_opcode, req_rx_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_kind, rsp_out_byte, rsp_last
//   csr      in         csr_write              csr_index, csr_data
//
// A tick or a byte that completes no command leaves req_stall low.
// A completed command runs its control program after the accept cycle: one step for a packet
// request, 18 for the set-centre ack and 24 for the get-centre reply, one step a cycle unless
// stalled. The next beat is taken once the program has loaded its final result into the output
// register. A stalled result register halts the program at its next emitting step.
// Reset is synchronous; no clearing pass is needed.
module meter_frame_command_handler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mfch_pkg::*;

   logic [15:0]      timeout_ff;
   logic [9:0]       max_width_ff;
   logic [9:0]       max_height_ff;
   logic             busy;
   logic             accept;
   start_type        start;
   frame_fields_type fields;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         max_width_ff  <= MAX_WIDTH_RESET;
         max_height_ff <= MAX_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TIMEOUT:    timeout_ff    <= csr_data;
            REG_MAX_WIDTH:  max_width_ff  <= csr_data[9:0];
            REG_MAX_HEIGHT: max_height_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   mfch_rx u_rx (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req_opcode),
      .rx_byte       (req_rx_byte),
      .timeout_ticks (timeout_ff),
      .start         (start),
      .fields        (fields)
   );

   mfch_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .fields       (fields),
      .max_width    (max_width_ff),
      .max_height   (max_height_ff),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
